>>> sv/blm_pkg.sv
// Shared constants and codes for the block list manager.
`default_nettype none

package blm_pkg;

    localparam int BLM_NUM_BLOCKS = 1024;
    localparam int BLM_NUM_LISTS  = 4;

    localparam int BLM_MODE_W  = 2;
    localparam int BLM_LIST_W  = 2;
    localparam int BLM_BLOCK_W = 10;
    localparam int BLM_KIND_W  = 2;
    localparam int BLM_STAT_W  = 2;
    localparam int BLM_COUNT_W = 11;

    localparam logic [BLM_MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [BLM_MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [BLM_MODE_W-1:0] MODE_FIND   = 2'd2;

    localparam logic [BLM_KIND_W-1:0] KIND_BLOCK = 2'd0;
    localparam logic [BLM_KIND_W-1:0] KIND_NONE  = 2'd1;

    localparam logic [BLM_STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [BLM_STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [BLM_STAT_W-1:0] STAT_EMPTY     = 2'd2;

endpackage

`default_nettype wire

>>> sv/blm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module blm_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/block_list_manager_unit.sv
// Top level: doubly linked block lists kept in next and previous link RAMs.
//
//  channel  | handshake                     | fields
//  ---------+-------------------------------+----------------------------------------------
//  request  | start high while busy low     | mode, list_select, block_index, pred_index,
//           |                               | pred_kind
//  result   | o_done high for one cycle     | status, found_pred, found_is_head, list_count
//
// Append goes through decode and a second write state; remove ends in decode, in the read-data
// state or in a second write state; find walks next links from the head, up to the list length,
// paced by the link RAM read latency. After reset a clearing pass writes null into every link
// entry with busy high. One request is in flight at a time; busy is low only while idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module block_list_manager_unit
    import blm_pkg::*;
#(
    parameter int NUM_BLOCKS = BLM_NUM_BLOCKS,
    parameter int NUM_LISTS  = BLM_NUM_LISTS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [BLM_MODE_W-1:0]  i_mode,
    input  wire logic [BLM_LIST_W-1:0]  i_list_select,
    input  wire logic [BLM_BLOCK_W-1:0] i_block_index,
    input  wire logic [BLM_BLOCK_W-1:0] i_pred_index,
    input  wire logic [BLM_KIND_W-1:0]  i_pred_kind,
    output logic                        o_done,
    output logic [BLM_STAT_W-1:0]       o_status,
    output logic [BLM_BLOCK_W-1:0]      o_found_pred,
    output logic                        o_found_is_head,
    output logic [BLM_COUNT_W-1:0]      o_list_count
);

    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int LW  = $clog2(NUM_BLOCKS + 1);
    localparam int LSW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);
    localparam logic [LW-1:0] ONE_LINK  = LW'(1);

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_DECODE  = 7'b0000100,
        S_APP2    = 7'b0001000,
        S_RM_DATA = 7'b0010000,
        S_RM_W2   = 7'b0100000,
        S_WALK    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    logic [BLM_MODE_W-1:0]  r_mode;
    logic [BLM_LIST_W-1:0]  r_list;
    logic [BLM_BLOCK_W-1:0] r_blk;
    logic [BLM_BLOCK_W-1:0] r_pred;
    logic [BLM_KIND_W-1:0]  r_kind;

    logic [LW-1:0] r_ptr, n_ptr;
    logic [LW-1:0] r_step, n_step;
    logic          r_rm_head, n_rm_head;

    logic [LW-1:0] r_head [NUM_LISTS];
    logic [LW-1:0] r_tail [NUM_LISTS];
    logic [LW-1:0] r_len  [NUM_LISTS];

    logic [LSW-1:0] w_lidx;
    logic [LW-1:0]  cur_head, cur_tail, cur_len, len_inc, len_dec;
    logic [LW-1:0]  blk_l, pred_l;
    logic           list_ok, blk_ok, pred_ok, empty;

    logic          upd_en;
    logic [LW-1:0] upd_head, upd_tail, upd_len;

    logic          nx_we, pv_we;
    logic [AW-1:0] nx_waddr, pv_waddr, nx_raddr, pv_raddr;
    logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    logic                  fin, fin_fhead;
    logic [BLM_STAT_W-1:0] fin_status;
    logic [LW-1:0]         fin_fpred;

    logic                   r_done;
    logic [BLM_STAT_W-1:0]  r_status;
    logic [BLM_BLOCK_W-1:0] r_fpred;
    logic                   r_fhead;
    logic [BLM_COUNT_W-1:0] r_count;

    function automatic logic is_blk(input logic [LW-1:0] v);
        return v < NULL_LINK;
    endfunction

    blm_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    blm_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    assign w_lidx   = LSW'(r_list);
    assign list_ok  = 32'(r_list) < NUM_LISTS;
    assign blk_ok   = 32'(r_blk) < NUM_BLOCKS;
    assign pred_ok  = 32'(r_pred) < NUM_BLOCKS;
    assign blk_l    = LW'(r_blk);
    assign pred_l   = LW'(r_pred);
    assign cur_head = r_head[w_lidx];
    assign cur_tail = r_tail[w_lidx];
    assign cur_len  = r_len[w_lidx];
    assign empty    = (cur_head == NULL_LINK) && (cur_tail == NULL_LINK);
    assign len_inc  = (cur_len < NULL_LINK) ? LW'(cur_len + ONE_LINK) : cur_len;
    assign len_dec  = (cur_len != '0) ? LW'(cur_len - ONE_LINK) : cur_len;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_ptr      = r_ptr;
        n_step     = r_step;
        n_rm_head  = r_rm_head;
        upd_en     = 1'b0;
        upd_head   = cur_head;
        upd_tail   = cur_tail;
        upd_len    = cur_len;
        nx_we      = 1'b0;
        nx_waddr   = AW'(r_blk);
        nx_wdata   = NULL_LINK;
        nx_raddr   = AW'(r_blk);
        pv_we      = 1'b0;
        pv_waddr   = AW'(r_blk);
        pv_wdata   = NULL_LINK;
        pv_raddr   = AW'(r_blk);
        fin        = 1'b0;
        fin_status = STAT_NOT_FOUND;
        fin_fpred  = '0;
        fin_fhead  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                nx_we      = 1'b1;
                nx_waddr   = r_clr_addr;
                pv_we      = 1'b1;
                pv_waddr   = r_clr_addr;
                n_clr_addr = AW'(r_clr_addr + AW'(1));
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!list_ok || !blk_ok) begin
                    fin = 1'b1;
                end else if (r_mode == MODE_APPEND) begin
                    nx_we    = is_blk(cur_tail);
                    nx_waddr = AW'(cur_tail);
                    nx_wdata = blk_l;
                    pv_we    = 1'b1;
                    pv_wdata = cur_tail;
                    upd_en   = 1'b1;
                    upd_head = empty ? blk_l : cur_head;
                    upd_tail = blk_l;
                    upd_len  = len_inc;
                    n_state  = S_APP2;
                end else if (r_mode == MODE_REMOVE) begin
                    if (r_kind > KIND_NONE) begin
                        fin = 1'b1;
                    end else if (empty) begin
                        fin        = 1'b1;
                        fin_status = STAT_EMPTY;
                    end else if (cur_head == cur_tail) begin
                        upd_en     = 1'b1;
                        upd_head   = NULL_LINK;
                        upd_tail   = NULL_LINK;
                        upd_len    = '0;
                        nx_we      = 1'b1;
                        pv_we      = 1'b1;
                        fin        = 1'b1;
                        fin_status = STAT_DONE;
                    end else if (r_kind == KIND_NONE && cur_head == blk_l
                                 && cur_len != ONE_LINK) begin
                        n_rm_head = 1'b1;
                        n_state   = S_RM_DATA;
                    end else if (r_kind == KIND_NONE || !pred_ok) begin
                        fin = 1'b1;
                    end else begin
                        n_rm_head = 1'b0;
                        n_state   = S_RM_DATA;
                    end
                end else if (r_mode == MODE_FIND) begin
                    if (empty) begin
                        fin        = 1'b1;
                        fin_status = STAT_EMPTY;
                    end else if (cur_head == cur_tail && cur_len == ONE_LINK
                                 && cur_head != blk_l) begin
                        fin = 1'b1;
                    end else if (cur_head == blk_l) begin
                        fin        = 1'b1;
                        fin_status = STAT_DONE;
                        fin_fhead  = 1'b1;
                    end else if (cur_len == '0 || !is_blk(cur_head)) begin
                        fin = 1'b1;
                    end else begin
                        nx_raddr = AW'(cur_head);
                        n_ptr    = cur_head;
                        n_step   = ONE_LINK;
                        n_state  = S_WALK;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            S_APP2: begin
                nx_we      = 1'b1;
                fin        = 1'b1;
                fin_status = STAT_DONE;
            end
            S_RM_DATA: begin
                if (r_rm_head) begin
                    upd_en     = 1'b1;
                    upd_head   = nx_rdata;
                    upd_len    = len_dec;
                    nx_we      = 1'b1;
                    pv_we      = is_blk(nx_rdata);
                    pv_waddr   = AW'(nx_rdata);
                    fin        = 1'b1;
                    fin_status = STAT_DONE;
                end else if (nx_rdata == NULL_LINK && cur_len != ONE_LINK) begin
                    upd_en     = 1'b1;
                    upd_tail   = pred_l;
                    upd_len    = len_dec;
                    nx_we      = 1'b1;
                    nx_waddr   = AW'(r_pred);
                    pv_we      = 1'b1;
                    fin        = 1'b1;
                    fin_status = STAT_DONE;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = AW'(r_pred);
                    nx_wdata = nx_rdata;
                    pv_we    = is_blk(nx_rdata);
                    pv_waddr = AW'(nx_rdata);
                    pv_wdata = pv_rdata;
                    n_state  = S_RM_W2;
                end
            end
            S_RM_W2: begin
                nx_we      = 1'b1;
                pv_we      = 1'b1;
                upd_en     = 1'b1;
                upd_len    = len_dec;
                fin        = 1'b1;
                fin_status = STAT_DONE;
            end
            S_WALK: begin
                if (nx_rdata == blk_l) begin
                    fin        = 1'b1;
                    fin_status = STAT_DONE;
                    fin_fpred  = r_ptr;
                end else if (r_step < cur_len && is_blk(nx_rdata)) begin
                    nx_raddr = AW'(nx_rdata);
                    n_ptr    = nx_rdata;
                    n_step   = LW'(r_step + ONE_LINK);
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head[i] <= NULL_LINK;
                r_tail[i] <= NULL_LINK;
                r_len[i]  <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_done     <= fin;
            if (upd_en) begin
                r_head[w_lidx] <= upd_head;
                r_tail[w_lidx] <= upd_tail;
                r_len[w_lidx]  <= upd_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_step    <= n_step;
        r_rm_head <= n_rm_head;
        if (r_state == S_IDLE && start) begin
            r_mode <= i_mode;
            r_list <= i_list_select;
            r_blk  <= i_block_index;
            r_pred <= i_pred_index;
            r_kind <= i_pred_kind;
        end
        if (fin) begin
            r_status <= fin_status;
            r_fpred  <= BLM_BLOCK_W'(fin_fpred);
            r_fhead  <= fin_fhead;
            r_count  <= list_ok ? BLM_COUNT_W'(upd_len) : '0;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found_pred    = r_fpred;
    assign o_found_is_head = r_fhead;
    assign o_list_count    = r_count;

endmodule

`default_nettype wire
